/* sv/twt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twt_pkg
// Shared types and constants of the transaction window tracker.
// ----------------------------------------------------------------------------
package twt_pkg;

   localparam int KIND_W = 2;
   localparam int TIME_W = 32;
   localparam int TRN_W  = 7;
   localparam int OP_W   = 7;
   localparam int EV_W   = 3;
   localparam int CSR_W  = 16;
   localparam int CSR_IDX_W = 1;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_SUBMIT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESPONSE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHECK    = 2'd2;

   // result events
   localparam logic [EV_W-1:0] EV_ASSIGNED   = 3'd0;
   localparam logic [EV_W-1:0] EV_FULL       = 3'd1;
   localparam logic [EV_W-1:0] EV_DELIVERED  = 3'd2;
   localparam logic [EV_W-1:0] EV_REJECTED   = 3'd3;
   localparam logic [EV_W-1:0] EV_UNEXPECTED = 3'd4;
   localparam logic [EV_W-1:0] EV_RESEND     = 3'd5;

   localparam logic [OP_W-1:0] SUBMIT_ACK_TYPE = 7'd51;

   // configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT    = 1'b1;
   localparam logic [CSR_W-1:0] CHECK_INTERVAL_RESET = 16'd30;
   localparam logic [CSR_W-1:0] ACK_TIMEOUT_RESET    = 16'd60;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_RESPOND,
      ST_CHK_RD,
      ST_CHK_EVAL,
      ST_CHK_FLUSH
   } state_type;

   typedef struct packed {
      logic [EV_W-1:0]  event_res;
      logic [TRN_W-1:0] slot_number;
      logic [TRN_W-1:0] outstanding;
      logic             last;
   } result_type;

endpackage

/* sv/twt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twt_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module twt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/transaction_window_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transaction_window_tracker
// Send window of WINDOW transaction numbers: assign, answer and time out.
// ----------------------------------------------------------------------------
// Transactions enter on req_* (valid/stall) and results leave on rsp_*
// (valid/stall); csr_we writes check_interval (index 0) or ack_timeout
// (index 1). The user must write these only while the block is idle; the
// block itself does not enforce this. One transaction is worked on at a time.
//  - submit: a free-slot search passes busy slots (at most WINDOW), one
//    result; a full window is answered at dispatch without a search.
//  - response: one result.
//  - time check: a RAM read, then an age test, for each slot over the whole
//    window, up to WINDOW results; a check that fails its interval test
//    finishes without results. The slot-time RAM is read one slot per access.
// Results go through an output register; a held result stalls the block
// only once it has its next result ready. Reset clears the busy bits, count,
// pointers and configuration at once; slot times need no clearing, being used
// only for busy slots.
// ----------------------------------------------------------------------------
module transaction_window_tracker #(
   parameter int WINDOW = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [twt_pkg::KIND_W-1:0]    req_kind,
   input  logic [twt_pkg::TIME_W-1:0]    req_now,
   input  logic [twt_pkg::TRN_W-1:0]     req_trn,
   input  logic [twt_pkg::OP_W-1:0]      req_op_type,
   input  logic                          req_accepted,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [twt_pkg::EV_W-1:0]      rsp_event_res,
   output logic [twt_pkg::TRN_W-1:0]     rsp_slot_number,
   output logic [twt_pkg::TRN_W-1:0]     rsp_outstanding,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [twt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [twt_pkg::CSR_W-1:0]     csr_wdata
);
   import twt_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  next_ff, next_in;
   logic [WINDOW-1:0] busy_ff, busy_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] last_check_ff, last_check_in;
   logic [CSR_W-1:0]  check_interval_ff, check_interval_in;
   logic [CSR_W-1:0]  ack_timeout_ff, ack_timeout_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   // latched transaction
   logic [KIND_W-1:0] kind_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TRN_W-1:0]  trn_ff;
   logic [OP_W-1:0]   op_ff;
   logic              acc_ff;

   logic              req_accept;
   logic              out_free;
   logic              out_load;
   result_type        out_data;
   logic [IDX_W-1:0]  ptr_wrap;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [TIME_W-1:0] ram_rd_data;
   logic              too_old;
   logic              check_due;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign ptr_wrap   = (ptr_ff == IDX_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;

   assign too_old = ({1'b0, ram_rd_data} + {{(TIME_W + 1 - CSR_W){1'b0}}, ack_timeout_ff})
                    < {1'b0, now_ff};
   assign check_due = (count_ff != '0) &&
                      ({1'b0, now_ff} >
                       ({1'b0, last_check_ff} +
                        {{(TIME_W + 1 - CSR_W){1'b0}}, check_interval_ff}));

   twt_ram #(
      .WIDTH (TIME_W),
      .DEPTH (WINDOW)
   ) u_slot_time (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (now_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // RAM writes happen only during a submit and reads only during a check,
   // so one slot is never read and written in overlapping cycles.
   always_comb begin
      state_in          = state_ff;
      ptr_in            = ptr_ff;
      next_in           = next_ff;
      busy_in           = busy_ff;
      count_in          = count_ff;
      last_check_in     = last_check_ff;
      check_interval_in = check_interval_ff;
      ack_timeout_in    = ack_timeout_ff;
      pend_valid_in     = pend_valid_ff;
      pend_in           = pend_ff;
      out_load          = 1'b0;
      out_data          = pend_ff;
      ram_wr_en         = 1'b0;
      ram_rd_en         = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_CHECK_INTERVAL: check_interval_in = csr_wdata;
            CSR_ACK_TIMEOUT:    ack_timeout_in    = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (kind_ff)
               KIND_SUBMIT: begin
                  if (count_ff >= CNT_W'(WINDOW)) begin
                     if (out_free) begin
                        out_load = 1'b1;
                        out_data = '{EV_FULL, '0, TRN_W'(count_ff), 1'b1};
                        state_in = ST_IDLE;
                     end
                  end else begin
                     ptr_in   = next_ff;
                     state_in = ST_SEARCH;
                  end
               end
               KIND_RESPONSE: begin
                  if (trn_ff >= TRN_W'(WINDOW)) begin
                     if (out_free) begin
                        out_load = 1'b1;
                        out_data = '{EV_UNEXPECTED, trn_ff, TRN_W'(count_ff), 1'b1};
                        state_in = ST_IDLE;
                     end
                  end else begin
                     ptr_in   = trn_ff[IDX_W-1:0];
                     state_in = ST_RESPOND;
                  end
               end
               KIND_CHECK: begin
                  if (check_due) begin
                     last_check_in = now_ff;
                     ptr_in        = '0;
                     state_in      = ST_CHK_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SEARCH: begin
            // a free slot is known to exist: advance until it is found
            if (busy_ff[ptr_ff]) begin
               ptr_in = ptr_wrap;
            end else if (out_free) begin
               busy_in[ptr_ff] = 1'b1;
               count_in        = count_ff + 1'b1;
               next_in         = ptr_wrap;
               ram_wr_en       = 1'b1;
               out_load        = 1'b1;
               out_data        = '{EV_ASSIGNED, TRN_W'(ptr_ff), TRN_W'(count_in), 1'b1};
               state_in        = ST_IDLE;
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               if (!busy_ff[ptr_ff] || op_ff != SUBMIT_ACK_TYPE) begin
                  out_data = '{EV_UNEXPECTED, trn_ff, TRN_W'(count_ff), 1'b1};
               end else begin
                  busy_in[ptr_ff] = 1'b0;
                  count_in        = count_ff - 1'b1;
                  out_data        = '{acc_ff ? EV_DELIVERED : EV_REJECTED, trn_ff,
                                      TRN_W'(count_in), 1'b1};
               end
            end
         end
         ST_CHK_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_CHK_EVAL;
         end
         ST_CHK_EVAL: begin
            // hold one resend back until the next is found, so last can be set
            if (!(busy_ff[ptr_ff] && too_old && pend_valid_ff && !out_free)) begin
               if (busy_ff[ptr_ff] && too_old) begin
                  busy_in[ptr_ff] = 1'b0;
                  count_in        = count_ff - 1'b1;
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     out_data = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = '{EV_RESEND, TRN_W'(ptr_ff), TRN_W'(count_in), 1'b0};
               end
               if (ptr_ff == IDX_W'(WINDOW - 1)) begin
                  state_in = ST_CHK_FLUSH;
               end else begin
                  ptr_in   = ptr_wrap;
                  state_in = ST_CHK_RD;
               end
            end
         end
         ST_CHK_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_data      = pend_ff;
               out_data.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         ptr_ff            <= '0;
         next_ff           <= '0;
         busy_ff           <= '0;
         count_ff          <= '0;
         last_check_ff     <= '0;
         check_interval_ff <= CHECK_INTERVAL_RESET;
         ack_timeout_ff    <= ACK_TIMEOUT_RESET;
         pend_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         ptr_ff            <= ptr_in;
         next_ff           <= next_in;
         busy_ff           <= busy_in;
         count_ff          <= count_in;
         last_check_ff     <= last_check_in;
         check_interval_ff <= check_interval_in;
         ack_timeout_ff    <= ack_timeout_in;
         pend_valid_ff     <= pend_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (req_accept) begin
         kind_ff <= req_kind;
         now_ff  <= req_now;
         trn_ff  <= req_trn;
         op_ff   <= req_op_type;
         acc_ff  <= req_accepted;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_ff.event_res;
   assign rsp_slot_number = rsp_ff.slot_number;
   assign rsp_outstanding = rsp_ff.outstanding;
   assign rsp_last        = rsp_ff.last;

   // count of unanswered slots always equals the busy bits set
   assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == int'(count_ff))
      else $error("unanswered count differs from busy slots");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("unanswered count exceeds window");

   // a held-back resend exists only while a check is running
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_CHK_RD || state_ff == ST_CHK_EVAL ||
                         state_ff == ST_CHK_FLUSH))
      else $error("pending resend outside a check");

   // an assigned slot is busy afterwards
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && ram_wr_en) |=> busy_ff[$past(ptr_ff)])
      else $error("assigned slot not marked busy");

endmodule
